// ===== hw/rtl/ttiq_pkg.sv =====
// Shared constants, codes and the sine table generator for the test tone / IQ generator.
package ttiq_pkg;

   // Parameter defaults
   localparam int DEF_MAX_CHANNELS     = 16;
   localparam int DEF_SINE_TABLE_DEPTH = 1024;
   localparam int DEF_SAMPLE_WIDTH     = 16;

   // Results per instant never exceed this; the channel tag is four bits wide
   localparam int RESULT_CAP = 16;
   localparam int CHAN_W     = 4;
   localparam int COUNT_W    = 5;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GEN_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_KIND   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IQ_STEP       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE     = 3'd5;

   // Register reset values
   localparam logic                RST_GEN_MODE      = 1'b1;
   localparam logic                RST_SIGNAL_KIND   = 1'b0;
   localparam logic [COUNT_W-1:0]  RST_CHANNEL_COUNT = 5'd1;
   localparam logic [31:0]         RST_TONE_STEP     = 32'd89478485;
   localparam logic [31:0]         RST_IQ_STEP       = 32'd89478485;
   localparam logic [15:0]         RST_AMPLITUDE     = 16'd32768;

   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Sequencer states
   typedef enum logic [6:0] {
      S_IDLE    = 7'b000_0001,
      S_READ    = 7'b000_0010,
      S_SCALE_A = 7'b000_0100,
      S_ROUND_A = 7'b000_1000,
      S_SCALE_B = 7'b001_0000,
      S_ROUND_B = 7'b010_0000,
      S_OUT     = 7'b100_0000
   } state_type;

   // Sine of phase t (full turn = 2^32), quarter-wave folded, Taylor series in Q30,
   // scaled to 2^(sw-1)-1 with round half up. Elaboration time only.
   function automatic longint exact_sine(input logic [31:0] t, input int sw);
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned fs;
      logic [1:0]      quad;
      quad = t[31:30];
      r    = {34'd0, t[29:0]};
      if (quad[0]) begin
         r = (64'd1 << 30) - r;
      end
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum  = sum - term;
      fs   = (64'd1 << (sw - 1)) - 64'd1;
      sum  = (sum * fs + (64'd1 << 29)) >> 30;
      if (sum > fs) begin
         sum = fs;
      end
      return quad[1] ? -longint'(sum) : longint'(sum);
   endfunction

endpackage

// ===== hw/rtl/test_tone_iq_generator.sv =====
// Test tone / IQ phasor generator: oscillator with a shared scaling multiplier.
//
// Usage: each transfer on the req_ channel is one sample instant; req_tdata[0] is
// the pause bit. A paused instant is accepted and gives nothing. Otherwise
// the block emits one rsp_ transfer per channel (chan_index counts from 0, rsp_tlast
// marks the final channel), then advances the 32-bit phase by tone_step (audio) or
// iq_step (IQ) unless gen_mode is silence.
// Sequence: the sequencer runs one channel at a time through a single sine table read
// port and a single amplitude multiplier. A result passes S_READ, S_SCALE_A and S_ROUND_A
// (cosine in IQ, sine in audio), in IQ also S_SCALE_B and S_ROUND_B (sine), then S_OUT;
// in silence it goes straight to S_OUT. An instant is taken from S_IDLE.
// req_tready is high only while the sequencer is idle; the last result of an instant
// may still sit in the output register when the next instant is taken.
// Stall: when rsp_tready is low the output register holds its transfer and the
// sequencer waits with the next result.
// Reset: synchronous, active high; registers return to their defaults (generate,
// audio, one channel, amplitude one half) and the phase to zero. The sine table is
// a constant ROM and needs no fill.
// Configuration: csr_we writes csr_wdata to register csr_index; write
// only while no instant is in flight.
module test_tone_iq_generator
   import ttiq_pkg::*;
#(
   parameter int MAX_CHANNELS     = DEF_MAX_CHANNELS,
   parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] pause, rest zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [SW-1:0] sample_a, [2SW-1:SW] sample_b, [2SW+3:2SW] chan_index, rest zero
   output logic [((2*SAMPLE_WIDTH+CHAN_W+7)/8)*8-1:0] rsp_tdata,
   output logic                          rsp_tlast,   // last
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int DATA_W  = ((2*SW+CHAN_W+7)/8)*8;
   localparam int ROM_AW  = $clog2(SINE_TABLE_DEPTH);
   localparam int PW      = SW - 1 + 16;
   localparam int CAP     = (MAX_CHANNELS < RESULT_CAP) ? MAX_CHANNELS : RESULT_CAP;

   typedef logic signed [SW-1:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         rom[k] = SW'(exact_sine(32'(k) << (32 - ROM_AW), SW));
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Configuration registers
   logic               gen_mode_ff;
   logic               signal_kind_ff;
   logic [COUNT_W-1:0] channel_count_ff;
   logic [31:0]        tone_step_ff;
   logic [31:0]        iq_step_ff;
   logic [15:0]        amplitude_ff;

   // Sequencer and datapath
   state_type          state_ff, state_in;
   logic [31:0]        phase_ff;
   logic [31:0]        p_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [CHAN_W-1:0]  last_idx_ff;
   logic signed [SW-1:0] rom_q_ff;
   logic [PW-1:0]      prod_ff;
   logic               neg_ff;
   logic signed [SW-1:0] a_ff;
   logic signed [SW-1:0] b_ff;

   // Output register
   logic               rsp_valid_ff;
   logic signed [SW-1:0] rsp_a_ff;
   logic signed [SW-1:0] rsp_b_ff;
   logic [CHAN_W-1:0]  rsp_chan_ff;
   logic               rsp_last_ff;

   logic               take;
   logic               out_load;
   logic               at_last;
   logic [COUNT_W-1:0] cnt_sat;
   logic [COUNT_W-1:0] cnt_eff;
   logic [31:0]        rd_phase;
   logic [SW-1:0]      rom_mag;
   logic               right_ch;
   logic [PW:0]        rnd_sum;
   logic [SW-1:0]      rnd_mag;
   logic signed [SW-1:0] rnd_val;

   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready && !req_tdata[0];
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign at_last    = (chan_ff == last_idx_ff);

   // Channel count: zero means one, saturate at the cap, audio is mono or stereo
   always_comb begin
      if (channel_count_ff == '0) begin
         cnt_sat = COUNT_W'(1);
      end else if (channel_count_ff > COUNT_W'(CAP)) begin
         cnt_sat = COUNT_W'(CAP);
      end else begin
         cnt_sat = channel_count_ff;
      end
      if (signal_kind_ff) begin
         cnt_eff = cnt_sat;
      end else begin
         cnt_eff = (cnt_sat == COUNT_W'(2)) ? COUNT_W'(2) : COUNT_W'(1);
      end
   end

   // Cosine read goes first in IQ, then the sine read at the plain phase
   assign rd_phase = (state_ff == S_READ && signal_kind_ff) ? (p_ff + QUARTER_TURN) : p_ff;
   assign rom_mag  = rom_q_ff[SW-1] ? SW'(-rom_q_ff) : SW'(rom_q_ff);
   assign right_ch = !signal_kind_ff && (chan_ff == CHAN_W'(1));

   // Round half away from zero: add half an LSB to the magnitude, restore the sign
   always_comb begin
      rnd_sum = {1'b0, prod_ff} + (right_ch ? ((PW+1)'(1) << 16) : ((PW+1)'(1) << 15));
      rnd_mag = right_ch ? SW'(rnd_sum >> 17) : SW'(rnd_sum >> 16);
      rnd_val = neg_ff ? -$signed(rnd_mag) : $signed(rnd_mag);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = gen_mode_ff ? S_READ : S_OUT;
            end
         end
         S_READ:    state_in = S_SCALE_A;
         S_SCALE_A: state_in = S_ROUND_A;
         S_ROUND_A: state_in = signal_kind_ff ? S_SCALE_B : S_OUT;
         S_SCALE_B: state_in = S_ROUND_B;
         S_ROUND_B: state_in = S_OUT;
         S_OUT: begin
            if (out_load) begin
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = gen_mode_ff ? S_READ : S_OUT;
               end
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         phase_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         gen_mode_ff      <= RST_GEN_MODE;
         signal_kind_ff   <= RST_SIGNAL_KIND;
         channel_count_ff <= RST_CHANNEL_COUNT;
         tone_step_ff     <= RST_TONE_STEP;
         iq_step_ff       <= RST_IQ_STEP;
         amplitude_ff     <= RST_AMPLITUDE;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // Advance the phase once the final result of the instant is handed off
         if (out_load && at_last && gen_mode_ff) begin
            phase_ff <= phase_ff + (signal_kind_ff ? iq_step_ff : tone_step_ff);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_GEN_MODE:      gen_mode_ff      <= csr_wdata[0];
               CSR_SIGNAL_KIND:   signal_kind_ff   <= csr_wdata[0];
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_TONE_STEP:     tone_step_ff     <= csr_wdata[31:0];
               CSR_IQ_STEP:       iq_step_ff       <= csr_wdata[31:0];
               CSR_AMPLITUDE:     amplitude_ff     <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rd_phase[31 -: ROM_AW]];
      if (take) begin
         chan_ff     <= '0;
         p_ff        <= phase_ff;
         last_idx_ff <= CHAN_W'(cnt_eff - COUNT_W'(1));
      end
      if (state_ff == S_SCALE_A || state_ff == S_SCALE_B) begin
         neg_ff  <= rom_q_ff[SW-1];
         prod_ff <= PW'(rom_mag[SW-2:0]) * PW'(amplitude_ff);
      end
      if (state_ff == S_ROUND_A) begin
         a_ff <= rnd_val;
      end
      if (state_ff == S_ROUND_B) begin
         b_ff <= rnd_val;
      end
      if (out_load) begin
         rsp_a_ff    <= gen_mode_ff ? a_ff : '0;
         rsp_b_ff    <= (gen_mode_ff && signal_kind_ff) ? b_ff : '0;
         rsp_chan_ff <= chan_ff;
         rsp_last_ff <= at_last;
         chan_ff     <= chan_ff + CHAN_W'(1);
         // In IQ, channel c runs at phase times (c+1): step by the base phase
         if (signal_kind_ff) begin
            p_ff <= p_ff + phase_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = DATA_W'({rsp_chan_ff, rsp_b_ff, rsp_a_ff});

   // The phase moves only when the final result of a generated instant is handed off
   assert property (@(posedge clock) disable iff (reset)
      !(out_load && at_last) |=> $stable(phase_ff))
      else $error("phase changed outside the end of an instant");

   // An unpaused instant starts a read, or goes straight to output in silence
   assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == S_READ) || (state_ff == S_OUT))
      else $error("sequencer did not start on a taken instant");

   // A stalled receiver holds the sequencer at the output step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && rsp_valid_ff && !rsp_tready |=> (state_ff == S_OUT))
      else $error("sequencer left the output step while the receiver stalled");

endmodule
